// File: hw/rtl/iblt_pkg.sv
// ----------------------------------------------------------------------------
// IMU bias correction and tilt: shared types and constants
// Datapath widths, the CORDIC vector type and the arctangent table.
// ----------------------------------------------------------------------------
package iblt_pkg;

    localparam int RAW_W    = 16;
    localparam int AXIS_W   = 17;
    localparam int ANGLE_W  = 16;
    localparam int CORD_W   = 28;
    localparam int ZACC_W   = 26;
    localparam int TBL_LEN  = 24;
    localparam int NUM_REGS = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [ZACC_W-1:0] HALF_TURN = 26'sd5898240;
    localparam logic signed [17:0]       ANG_LIMIT = 18'sd23040;
    localparam logic signed [17:0]       INV_GAIN  = 18'sd39797;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_BIAS_X = 3'd0,
        REG_ACCEL_BIAS_Y = 3'd1,
        REG_ACCEL_BIAS_Z = 3'd2,
        REG_GYRO_BIAS_X  = 3'd3,
        REG_GYRO_BIAS_Y  = 3'd4,
        REG_GYRO_BIAS_Z  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ZACC_W-1:0] z;
    } cordic_vec_t;

    // atan(2^-i) in degrees times 32768, rounded to nearest.
    localparam logic signed [ZACC_W-1:0] ATAN_TBL [TBL_LEN] = '{
        26'sd1474560, 26'sd870484, 26'sd459940, 26'sd233473, 26'sd117189,
        26'sd58652, 26'sd29333, 26'sd14667, 26'sd7334, 26'sd3667, 26'sd1833,
        26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29, 26'sd14,
        26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0, 26'sd0
    };

    // Round an angle in 1/32768 degree to 1/128 degree and saturate.
    function automatic logic signed [ANGLE_W-1:0] to_angle(
        input logic signed [ZACC_W-1:0] z
    );
        logic signed [ZACC_W:0] sum;
        logic signed [17:0]     a;
        sum = {z[ZACC_W-1], z} + (ZACC_W+1)'(128);
        a   = 18'(sum >>> 8);
        if (a > ANG_LIMIT)
        begin
            a = ANG_LIMIT;
        end
        else if (a < -ANG_LIMIT)
        begin
            a = -ANG_LIMIT;
        end
        return a[ANGLE_W-1:0];
    endfunction

endpackage

// File: hw/rtl/iblt_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation toward y = 0 with a fixed shift, registered, carrying a
// side word along with the vector.
// ----------------------------------------------------------------------------
module iblt_cordic_cell
    import iblt_pkg::*;
#(
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cordic_vec_t       in_vec,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output cordic_vec_t       out_vec,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    cordic_vec_t       vec_reg;
    cordic_vec_t       vec_next;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        if (!in_vec.y[CORD_W-1])
        begin
            vec_next.x = in_vec.x + (in_vec.y >>> SHIFT);
            vec_next.y = in_vec.y - (in_vec.x >>> SHIFT);
            vec_next.z = in_vec.z + ATAN_TBL[SHIFT];
        end
        else
        begin
            vec_next.x = in_vec.x - (in_vec.y >>> SHIFT);
            vec_next.y = in_vec.y + (in_vec.x >>> SHIFT);
            vec_next.z = in_vec.z - ATAN_TBL[SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

// File: hw/rtl/iblt_cordic_chain.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring chain
// A row of STAGES cells, one shift each, that hand the vector on every cycle while en is high.
// ----------------------------------------------------------------------------
module iblt_cordic_chain
    import iblt_pkg::*;
#(
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cordic_vec_t       in_vec,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output cordic_vec_t       out_vec,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_w [STAGES+1];
    cordic_vec_t       vec_w   [STAGES+1];
    logic [SIDE_W-1:0] side_w  [STAGES+1];

    assign valid_w[0] = in_valid;
    assign vec_w[0]   = in_vec;
    assign side_w[0]  = in_side;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        iblt_cordic_cell #(
            .SHIFT  (i),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_w[i]),
            .in_vec    (vec_w[i]),
            .in_side   (side_w[i]),
            .out_valid (valid_w[i+1]),
            .out_vec   (vec_w[i+1]),
            .out_side  (side_w[i+1])
        );
    end

    assign out_valid = valid_w[STAGES];
    assign out_vec   = vec_w[STAGES];
    assign out_side  = side_w[STAGES];

endmodule

// File: hw/rtl/imu_bias_correct_tilt.sv
// ----------------------------------------------------------------------------
// IMU bias correction and accelerometer tilt
// Subtracts per-axis biases and derives roll and pitch by two CORDIC chains.
// ----------------------------------------------------------------------------
// One item is taken every cycle while the output side keeps up; each item
// passes through the bias stage, roll chain, gain multiply, pitch chain and
// output register in that order. The whole pipeline advances together, so a
// stall on the output holds every stage, and the input is ready whenever the
// output register is empty or being taken. Bias registers are written through
// the config channel, which is always ready, and should only change while no
// item is in flight. Angles are in 1/128 degree.
module imu_bias_correct_tilt
    import iblt_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
    input  logic [95:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, pitch, roll, 2 zero bits
    output logic [135:0]         m_axis_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAW_W-1:0]     cfg_data
);

    localparam int SENS_W  = 6 * AXIS_W;
    localparam int SIDE1_W = SENS_W + 1;
    localparam int SIDE2_W = SENS_W + ANGLE_W + 1;

    logic               en;
    logic [RAW_W-1:0]   bias_reg [NUM_REGS];

    logic               v0_reg;
    cordic_vec_t        vec0_reg;
    logic [SIDE1_W-1:0] side0_reg;

    logic signed [AXIS_W-1:0] diff [NUM_REGS];
    logic [SENS_W-1:0]  sens_next;
    cordic_vec_t        vec0_next;

    logic               v1;
    cordic_vec_t        vec1;
    logic [SIDE1_W-1:0] side1;

    logic               v2_reg;
    cordic_vec_t        vec2_reg;
    logic [SIDE2_W-1:0] side2_reg;
    logic signed [CORD_W+17:0] prod;
    logic signed [CORD_W-1:0]  mag;
    logic signed [AXIS_W-1:0]  ax1;

    logic               v3;
    cordic_vec_t        vec3;
    logic [SIDE2_W-1:0] side3;

    logic               m_valid_reg;
    logic [135:0]       m_data_reg;
    logic signed [ANGLE_W-1:0] pitch;

    assign en            = m_axis_tready || !m_valid_reg;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                bias_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ACCEL_BIAS_X: bias_reg[0] <= cfg_data;
                REG_ACCEL_BIAS_Y: bias_reg[1] <= cfg_data;
                REG_ACCEL_BIAS_Z: bias_reg[2] <= cfg_data;
                REG_GYRO_BIAS_X:  bias_reg[3] <= cfg_data;
                REG_GYRO_BIAS_Y:  bias_reg[4] <= cfg_data;
                REG_GYRO_BIAS_Z:  bias_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Bias subtraction and roll setup: a vector with negative z is turned
    // half a revolution so the chain starts in the right half-plane.
    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            diff[i] = AXIS_W'($signed(s_axis_tdata[i*RAW_W +: RAW_W]))
                    - AXIS_W'($signed(bias_reg[i]));
            sens_next[i*AXIS_W +: AXIS_W] = diff[i];
        end
        vec0_next.x = CORD_W'(diff[2]) <<< 8;
        vec0_next.y = CORD_W'(diff[1]) <<< 8;
        vec0_next.z = '0;
        if (diff[2][AXIS_W-1])
        begin
            vec0_next.x = -vec0_next.x;
            vec0_next.y = -vec0_next.y;
            vec0_next.z = diff[1][AXIS_W-1] ? -HALF_TURN : HALF_TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec0_reg  <= vec0_next;
            side0_reg <= {(diff[1] == '0) && (diff[2] == '0), sens_next};
        end
    end

    iblt_cordic_chain #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SIDE1_W)
    ) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .in_vec    (vec0_reg),
        .in_side   (side0_reg),
        .out_valid (v1),
        .out_vec   (vec1),
        .out_side  (side1)
    );

    // Gain compensation of the magnitude, then the pitch vector.
    assign prod = (CORD_W+18)'(vec1.x) * (CORD_W+18)'(INV_GAIN)
                + (CORD_W+18)'(32768);
    assign mag  = side1[SENS_W] ? '0 : CORD_W'(prod >>> 16);
    assign ax1  = side1[AXIS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec2_reg.x <= mag;
            vec2_reg.y <= CORD_W'(ax1) <<< 8;
            vec2_reg.z <= '0;
            side2_reg  <= {(ax1 == '0) && (mag == '0),
                           side1[SENS_W] ? ANGLE_W'(0) : to_angle(vec1.z),
                           side1[SENS_W-1:0]};
        end
    end

    iblt_cordic_chain #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (SIDE2_W)
    ) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_vec    (vec2_reg),
        .in_side   (side2_reg),
        .out_valid (v3),
        .out_vec   (vec3),
        .out_side  (side3)
    );

    assign pitch = side3[SIDE2_W-1] ? ANGLE_W'(0) : to_angle(vec3.z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= v3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg <= {2'b00, side3[SENS_W +: ANGLE_W], pitch, side3[SENS_W-1:0]};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
